@@ rtl/gdd_pkg.sv @@
// Shared types, widths and calendar helpers for the date difference block.
package gdd_pkg;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int DIFF_W = 23;
    localparam int C100_W = 7;
    localparam int CEN_W  = 2;

    localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1);
    localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);

    localparam logic [MON_W-1:0]  MONTH_FIRST = MON_W'(1);
    localparam logic [MON_W-1:0]  MONTH_LAST  = MON_W'(12);

    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [8:0] DAYS_LEAP   = 9'd366;
    localparam logic [4:0] FEB_LEAP    = 5'd29;

    // centuries and the 100-year position within the current run of years
    localparam logic [C100_W-1:0] C100_LAST = C100_W'(99);

    typedef struct packed {
        logic              sub;
        logic [DIFF_W-1:0] a;
        logic [DIFF_W-1:0] b;
    } t_alu_op;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic              leap;
    } t_year_info;

    typedef struct packed {
        logic start;
        logic step;
    } t_year_ctl;

    // month lengths, January first; February follows the leap flag
    function automatic logic [4:0] month_days(input logic [MON_W-1:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m)
                4'd1:    len = 5'd31;
                4'd2:    len = leap ? FEB_LEAP : 5'd28;
                4'd3:    len = 5'd31;
                4'd4:    len = 5'd30;
                4'd5:    len = 5'd31;
                4'd6:    len = 5'd30;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd31;
                4'd9:    len = 5'd30;
                4'd10:   len = 5'd31;
                4'd11:   len = 5'd30;
                4'd12:   len = 5'd31;
                default: len = 5'd0;
            endcase
            return len;
        end
    endfunction

    function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] r;
        begin
            if (y < YEAR_MIN) begin
                r = YEAR_MIN;
            end else if (y > YEAR_MAX) begin
                r = YEAR_MAX;
            end else begin
                r = y;
            end
            return r;
        end
    endfunction

endpackage

@@ rtl/gregorian_date_difference.sv @@
// Gregorian date difference: signed days from the first date to the second.
// One transaction at a time: s_axis_tready is high only while idle. The year walk,
// one year a cycle through a single shared adder, counts from year 1 up to the later
// (clamped) year; the month walks then add the later date's month lengths and take
// off the earlier date's. Years below 1 or above 9999 are clamped. Setting
// count_end_day (address 0) adds one to the magnitude.
module gregorian_date_difference (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // first_day, first_month, first_year, second_day, second_month, second_year, pad
    input  logic [47:0] s_axis_tdata,
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // day_difference, pad
    output logic [23:0] m_axis_tdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_YEAR = 3'd1;
    localparam logic [2:0] ST_MHI  = 3'd2;
    localparam logic [2:0] ST_MLO  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_NEG  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam logic [2:0] ADDR_COUNT_END = 3'd0;

    logic [2:0] r_state, n_state;
    logic       r_count_end_day;

    logic [gdd_pkg::DAY_W-1:0]  r_lo_d, r_hi_d, n_lo_d, n_hi_d;
    logic [gdd_pkg::MON_W-1:0]  r_lo_m, r_hi_m, n_lo_m, n_hi_m;
    logic [gdd_pkg::YEAR_W-1:0] r_lo_y, r_hi_y, n_lo_y, n_hi_y;
    logic                       r_negative, n_negative;
    logic                       r_equal, n_equal;
    logic                       r_leap_lo, n_leap_lo;
    logic                       r_leap_hi, n_leap_hi;
    logic [gdd_pkg::MON_W-1:0]  r_mon, n_mon;
    logic [gdd_pkg::DIFF_W-1:0] r_acc, n_acc;

    gdd_pkg::t_alu_op           alu_op;
    logic                       alu_en;
    logic [gdd_pkg::DIFF_W-1:0] alu_res;
    gdd_pkg::t_year_ctl         year_ctl;
    gdd_pkg::t_year_info        year_info;

    logic [gdd_pkg::DAY_W-1:0]  in_d1, in_d2;
    logic [gdd_pkg::MON_W-1:0]  in_m1, in_m2;
    logic [gdd_pkg::YEAR_W-1:0] in_y1, in_y2;
    logic                       in_before, in_equal;
    logic                       in_accept;

    gdd_alu u_alu (
        .i_op     (alu_op),
        .o_result (alu_res)
    );

    gdd_calendar u_calendar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (year_ctl),
        .o_info  (year_info)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_COUNT_END) ? {31'd0, r_count_end_day} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_end_day <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_COUNT_END)) begin
            r_count_end_day <= pwdata[0];
        end
    end

    // input unpacking and ordering
    assign in_d1 = s_axis_tdata[4:0];
    assign in_m1 = s_axis_tdata[8:5];
    assign in_y1 = gdd_pkg::clamp_year(s_axis_tdata[22:9]);
    assign in_d2 = s_axis_tdata[27:23];
    assign in_m2 = s_axis_tdata[31:28];
    assign in_y2 = gdd_pkg::clamp_year(s_axis_tdata[45:32]);

    always_comb begin
        if (in_y1 != in_y2) begin
            in_before = in_y1 < in_y2;
        end else if (in_m1 != in_m2) begin
            in_before = in_m1 < in_m2;
        end else begin
            in_before = in_d1 < in_d2;
        end
    end

    assign in_equal  = (in_y1 == in_y2) && (in_m1 == in_m2) && (in_d1 == in_d2);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {1'b0, r_acc};

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_lo_d     = r_lo_d;
        n_lo_m     = r_lo_m;
        n_lo_y     = r_lo_y;
        n_hi_d     = r_hi_d;
        n_hi_m     = r_hi_m;
        n_hi_y     = r_hi_y;
        n_negative = r_negative;
        n_equal    = r_equal;
        n_leap_lo  = r_leap_lo;
        n_leap_hi  = r_leap_hi;
        n_mon      = r_mon;
        n_acc      = r_acc;
        alu_en     = 1'b0;
        alu_op.sub = 1'b0;
        alu_op.a   = r_acc;
        alu_op.b   = '0;
        year_ctl.start = 1'b0;
        year_ctl.step  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_before) begin
                        n_lo_d = in_d1; n_lo_m = in_m1; n_lo_y = in_y1;
                        n_hi_d = in_d2; n_hi_m = in_m2; n_hi_y = in_y2;
                    end else begin
                        n_lo_d = in_d2; n_lo_m = in_m2; n_lo_y = in_y2;
                        n_hi_d = in_d1; n_hi_m = in_m1; n_hi_y = in_y1;
                    end
                    n_negative     = !in_before && !in_equal;
                    n_equal        = in_equal;
                    n_acc          = '0;
                    year_ctl.start = 1'b1;
                    n_state        = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (year_info.year == r_lo_y) begin
                    n_leap_lo = year_info.leap;
                end
                if (year_info.year == r_hi_y) begin
                    // last year reached: start the later date's day of year
                    n_leap_hi = year_info.leap;
                    alu_en    = 1'b1;
                    alu_op.b  = gdd_pkg::DIFF_W'(r_hi_d);
                    n_mon     = gdd_pkg::MONTH_FIRST;
                    n_state   = ST_MHI;
                end else begin
                    year_ctl.step = 1'b1;
                    if (year_info.year >= r_lo_y) begin
                        alu_en   = 1'b1;
                        alu_op.b = gdd_pkg::DIFF_W'(year_info.leap ? gdd_pkg::DAYS_LEAP
                                                                   : gdd_pkg::DAYS_COMMON);
                    end
                end
            end
            ST_MHI: begin
                alu_en = 1'b1;
                if ((r_mon < r_hi_m) && (r_mon <= gdd_pkg::MONTH_LAST)) begin
                    alu_op.b = gdd_pkg::DIFF_W'(gdd_pkg::month_days(r_mon, r_leap_hi));
                    n_mon    = r_mon + gdd_pkg::MON_W'(1);
                end else begin
                    alu_op.sub = 1'b1;
                    alu_op.b   = gdd_pkg::DIFF_W'(r_lo_d);
                    n_mon      = gdd_pkg::MONTH_FIRST;
                    n_state    = ST_MLO;
                end
            end
            ST_MLO: begin
                if ((r_mon < r_lo_m) && (r_mon <= gdd_pkg::MONTH_LAST)) begin
                    alu_en     = 1'b1;
                    alu_op.sub = 1'b1;
                    alu_op.b   = gdd_pkg::DIFF_W'(gdd_pkg::month_days(r_mon, r_leap_lo));
                    n_mon      = r_mon + gdd_pkg::MON_W'(1);
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // equal dates give a zero span before the end day is added
                alu_en   = 1'b1;
                alu_op.a = r_equal ? '0 : r_acc;
                alu_op.b = gdd_pkg::DIFF_W'(r_count_end_day);
                n_state  = r_negative ? ST_NEG : ST_OUT;
            end
            ST_NEG: begin
                alu_en     = 1'b1;
                alu_op.sub = 1'b1;
                alu_op.a   = '0;
                alu_op.b   = r_acc;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (alu_en) begin
            n_acc = alu_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_d     <= n_lo_d;
        r_lo_m     <= n_lo_m;
        r_lo_y     <= n_lo_y;
        r_hi_d     <= n_hi_d;
        r_hi_m     <= n_hi_m;
        r_hi_y     <= n_hi_y;
        r_negative <= n_negative;
        r_equal    <= n_equal;
        r_leap_lo  <= n_leap_lo;
        r_leap_hi  <= n_leap_hi;
        r_mon      <= n_mon;
        r_acc      <= n_acc;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a date pair is in progress");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("ready and result valid together");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_YEAR) |-> (year_info.year <= r_hi_y))
        else $error("year walk passed the later year");

    a_month_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_MHI) || (r_state == ST_MLO)) |-> (r_mon <= 4'd13))
        else $error("month counter out of range");

    a_neg_only_if_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NEG) |-> (r_negative && !r_equal))
        else $error("negation of a non-negative span");

endmodule

@@ rtl/gdd_alu.sv @@
// Shared add/subtract unit for the day accumulator.
module gdd_alu (
    input  gdd_pkg::t_alu_op             i_op,
    output logic [gdd_pkg::DIFF_W-1:0]   o_result
);

    always_comb begin
        if (i_op.sub) begin
            o_result = i_op.a - i_op.b;
        end else begin
            o_result = i_op.a + i_op.b;
        end
    end

endmodule

@@ rtl/gdd_calendar.sv @@
// Year walker: counts years from 1 and tracks the 4/100/400 leap rule by counters.
module gdd_calendar (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gdd_pkg::t_year_ctl    i_ctl,
    output gdd_pkg::t_year_info   o_info
);

    logic [gdd_pkg::YEAR_W-1:0] r_year, n_year;
    logic [gdd_pkg::C100_W-1:0] r_c100, n_c100;   // year mod 100
    logic [gdd_pkg::CEN_W-1:0]  r_cen,  n_cen;    // (year / 100) mod 4

    always_comb begin
        n_year = r_year;
        n_c100 = r_c100;
        n_cen  = r_cen;
        if (i_ctl.start) begin
            n_year = gdd_pkg::YEAR_MIN;
            n_c100 = gdd_pkg::C100_W'(1);
            n_cen  = '0;
        end else if (i_ctl.step) begin
            n_year = r_year + gdd_pkg::YEAR_W'(1);
            if (r_c100 == gdd_pkg::C100_LAST) begin
                n_c100 = '0;
                n_cen  = r_cen + gdd_pkg::CEN_W'(1);
            end else begin
                n_c100 = r_c100 + gdd_pkg::C100_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year <= gdd_pkg::YEAR_MIN;
            r_c100 <= gdd_pkg::C100_W'(1);
            r_cen  <= '0;
        end else begin
            r_year <= n_year;
            r_c100 <= n_c100;
            r_cen  <= n_cen;
        end
    end

    // y mod 4 is the low two bits of y mod 100
    assign o_info.year = r_year;
    assign o_info.leap = ((r_c100[1:0] == 2'd0) && (r_c100 != '0))
                       || ((r_c100 == '0) && (r_cen == '0));

endmodule

@@ dv/gregorian_date_difference_test.sv @@
// Self-checking testbench for the Gregorian date difference block.
`timescale 1ns / 100ps

module gregorian_date_difference_test;

    localparam logic [2:0] ADDR_COUNT_END_DAY = 3'd0;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int IDLE_PERCENT   = 18;

    typedef struct packed {
        logic [gdd_pkg::YEAR_W-1:0] year;
        logic [gdd_pkg::MON_W-1:0]  month;
        logic [gdd_pkg::DAY_W-1:0]  day;
    } t_date;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // first_day, first_month, first_year, second_day, second_month, second_year, pad
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // day_difference, pad
    logic [23:0] m_axis_tdata;

    logic [gdd_pkg::DIFF_W-1:0] expected_diffs[$];
    bit                end_day_setting = 1'b0;
    bit                steady = 1'b0;
    int                mismatch_count = 0;
    int                quiet_cycles = 0;

    gregorian_date_difference i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------- calendar

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
        case (m)
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic logic [gdd_pkg::YEAR_W-1:0] bounded_year(
        input logic [gdd_pkg::YEAR_W-1:0] y);
        if (y == '0) begin
            return gdd_pkg::YEAR_W'(1);
        end
        if (y > gdd_pkg::YEAR_W'(9999)) begin
            return gdd_pkg::YEAR_W'(9999);
        end
        return y;
    endfunction

    // days from 1 Jan of year 1; months past December add nothing
    function automatic longint date_ordinal(input t_date d);
        longint      p;
        longint      total;
        int unsigned y;
        begin
            y = 32'(d.year);
            p = longint'(y) - 1;
            total = p * 365 + p / 4 - p / 100 + p / 400 + longint'(d.day);
            for (int m = 1; m < int'(d.month) && m <= 12; m++) begin
                total += longint'(days_in_month(m, is_leap(y)));
            end
            return total;
        end
    endfunction

    function automatic logic [gdd_pkg::DIFF_W-1:0] predict_day_difference(
        input t_date from_date, input t_date to_date, input bit end_day);
        t_date  a;
        t_date  b;
        logic [22:0] key_a;
        logic [22:0] key_b;
        longint span;
        bit     negative;
        begin
            a = from_date;
            b = to_date;
            a.year = bounded_year(from_date.year);
            b.year = bounded_year(to_date.year);
            key_a = a;
            key_b = b;
            // ordering is by (year, month, day) fields, so odd days can make the span wrap
            if (key_a < key_b) begin
                span = date_ordinal(b) - date_ordinal(a);
                negative = 1'b0;
            end else begin
                span = date_ordinal(a) - date_ordinal(b);
                negative = (key_a != key_b);
            end
            if (end_day) begin
                span = span + 1;
            end
            if (negative) begin
                span = -span;
            end
            return span[gdd_pkg::DIFF_W-1:0];
        end
    endfunction

    function automatic t_date calendar_date(input int unsigned day, input int unsigned month,
                                            input int unsigned year);
        t_date d;
        begin
            d.day = gdd_pkg::DAY_W'(day);
            d.month = gdd_pkg::MON_W'(month);
            d.year = gdd_pkg::YEAR_W'(year);
            return d;
        end
    endfunction

    function automatic t_date random_valid_date(input int unsigned ylo, input int unsigned yhi);
        t_date d;
        begin
            d.year = gdd_pkg::YEAR_W'($urandom_range(yhi, ylo));
            d.month = gdd_pkg::MON_W'($urandom_range(12, 1));
            d.day = gdd_pkg::DAY_W'($urandom_range(
                        days_in_month(32'(d.month), is_leap(32'(d.year))), 1));
            return d;
        end
    endfunction

    function automatic t_date random_raw_date(input int unsigned yhi);
        t_date d;
        begin
            d.day = gdd_pkg::DAY_W'($urandom_range(31, 0));
            d.month = gdd_pkg::MON_W'($urandom_range(15, 0));
            d.year = gdd_pkg::YEAR_W'($urandom_range(yhi, 0));
            return d;
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        logic [gdd_pkg::DIFF_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_diffs.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d",
                                          $signed(m_axis_tdata[gdd_pkg::DIFF_W-1:0])));
            end else begin
                want = expected_diffs.pop_front();
                if (m_axis_tdata[gdd_pkg::DIFF_W-1:0] !== want) begin
                    report_mismatch($sformatf("day_difference %0d, expected %0d",
                                              $signed(m_axis_tdata[gdd_pkg::DIFF_W-1:0]),
                                              $signed(want)));
                end
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("gregorian_date_difference_test NOT OK");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_date_pair(input t_date from_date, input t_date to_date);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata <= {2'b00, to_date, from_date};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_diffs.push_back(predict_day_difference(from_date, to_date, end_day_setting));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_diffs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // write then read back; only while nothing is in flight
    task automatic set_end_day_count(input bit value);
        logic [31:0] wdata;
        begin
            wdata = $urandom;
            wdata[0] = value;
            @(negedge i_clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= ADDR_COUNT_END_DAY;
            pwdata <= wdata;
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            end_day_setting = value;
            @(negedge i_clk);
            pwrite <= 1'b0;
            penable <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata !== {31'd0, value}) begin
                report_mismatch($sformatf("count_end_day read back %0h, expected %0h",
                                          prdata, value));
            end
            @(negedge i_clk);
            psel <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic send_random_pair();
        int    kind;
        t_date from_date;
        t_date to_date;
        begin
            kind = $urandom_range(99);
            if (kind < 10) begin
                // full 14-bit years: slow, so kept rare
                from_date = random_raw_date(16383);
                to_date = random_raw_date(16383);
            end else if (kind < 28) begin
                from_date = random_raw_date(1023);
                to_date = random_raw_date(1023);
            end else if (kind < 33) begin
                from_date = random_valid_date(1, 700);
                to_date = from_date;
            end else begin
                from_date = random_valid_date(1, 700);
                if ($urandom_range(1)) begin
                    to_date = random_valid_date(32'(from_date.year),
                                                32'(from_date.year) + 32'd1);
                end else begin
                    to_date = random_valid_date(1, 700);
                end
            end
            send_date_pair(from_date, to_date);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_calendar_edges();
        send_date_pair(calendar_date(1, 1, 2000), calendar_date(1, 1, 2000));
        send_date_pair(calendar_date(1, 3, 2000), calendar_date(28, 2, 2000));
        send_date_pair(calendar_date(1, 3, 1900), calendar_date(28, 2, 1900));
        send_date_pair(calendar_date(29, 2, 2004), calendar_date(1, 3, 2005));
        // year 0 clamps to 1
        send_date_pair(calendar_date(1, 1, 0), calendar_date(1, 1, 1));
        send_date_pair(calendar_date(5, 0, 10), calendar_date(5, 1, 10));
        send_date_pair(calendar_date(1, 13, 50), calendar_date(1, 15, 51));
        send_date_pair(calendar_date(0, 2, 2001), calendar_date(31, 2, 2001));
        send_date_pair(calendar_date(31, 12, 9999), calendar_date(1, 1, 1));
        send_date_pair(calendar_date(1, 1, 0), calendar_date(31, 12, 16383));
        send_date_pair(calendar_date(31, 15, 16383), calendar_date(0, 0, 0));
    endtask

    task automatic test_end_day_count();
        wait_drained();
        set_end_day_count(1'b1);
        send_date_pair(calendar_date(15, 6, 1234), calendar_date(15, 6, 1234));
        send_date_pair(calendar_date(1, 1, 1), calendar_date(31, 12, 9999));
        send_date_pair(calendar_date(2, 1, 2), calendar_date(1, 1, 2));
        send_date_pair(calendar_date(31, 12, 399), calendar_date(1, 1, 401));
        send_date_pair(calendar_date(1, 1, 1600), calendar_date(1, 1, 1601));
    endtask

    task automatic test_random_traffic();
        wait_drained();
        set_end_day_count(1'b0);
        repeat (15) send_random_pair();
        // hold off until the block has handed back everything
        wait_drained();
        repeat (15) send_random_pair();
        wait_drained();
        set_end_day_count(1'b1);
        steady = 1'b1;
        repeat (30) send_random_pair();
        wait_drained();
        steady = 1'b0;
        set_end_day_count(1'b0);
        repeat (24) send_random_pair();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_calendar_edges();
        test_end_day_count();
        test_random_traffic();
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("gregorian_date_difference_test OK");
        end else begin
            $display("gregorian_date_difference_test NOT OK");
        end
        $finish;
    end

endmodule

@@ gregorian_date_difference.f @@
rtl/gdd_pkg.sv
rtl/gdd_alu.sv
rtl/gdd_calendar.sv
rtl/gregorian_date_difference.sv
dv/gregorian_date_difference_test.sv
